FILE: rtl/slcan_command_line_parser_macros.svh
// Assertion helpers for the command line parser. Each expects clk and arst_n
// in the scope of the module that uses it.
`ifndef SLCAN_COMMAND_LINE_PARSER_MACROS_SVH
`define SLCAN_COMMAND_LINE_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define SLCP_ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SLCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SLCP_ASSERT_HOLDS(lbl, prop, msg)
`define SLCP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/slcp_pkg.sv
// ----------------------------------------------------------------------------
// slcp_pkg
// Shared types, character codes and helpers of the command line parser.
// ----------------------------------------------------------------------------
package slcp_pkg;

	localparam int unsigned LINE_CHARS_MAX = 64;
	localparam int unsigned CNT_W          = $clog2(LINE_CHARS_MAX);

	localparam logic [7:0] CHAR_CR  = 8'h0d;
	localparam logic [7:0] CHAR_LF  = 8'h0a;
	localparam logic [7:0] CHAR_STD = 8'h74; // 't'
	localparam logic [7:0] CHAR_EXT = 8'h54; // 'T'
	localparam logic [7:0] CHAR_VER = 8'h56; // 'V'

	localparam logic [CNT_W-1:0] STD_DIGITS = CNT_W'(3);
	localparam logic [CNT_W-1:0] EXT_DIGITS = CNT_W'(8);
	localparam logic [4:0]       MAX_LEN    = 5'd8;

	typedef enum logic [1:0] {
		ST_FRAME   = 2'd0,
		ST_ERROR   = 2'd1,
		ST_VERSION = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		KIND_NONE  = 5'b00001,
		KIND_STD   = 5'b00010,
		KIND_EXT   = 5'b00100,
		KIND_VER   = 5'b01000,
		KIND_OTHER = 5'b10000
	} kind_t;

	typedef struct packed {
		status_t     status;
		logic        is_extended;
		logic [31:0] identifier;
		logic [3:0]  data_length;
		logic [63:0] data_bytes;
	} result_t;

	// Bit 4 set: not a hex digit. Otherwise bits 3:0 hold the nibble.
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [4:0] n;
		if (c >= 8'h30 && c <= 8'h39) begin
			n = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			n = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			n = {1'b0, 4'(c - 8'h37)};
		end else begin
			n = 5'h10;
		end
		return n;
	endfunction

endpackage

FILE: rtl/slcp_if.sv
// ----------------------------------------------------------------------------
// slcp_if
// Valid/ready channels: host characters in, parsed command results out.
// ----------------------------------------------------------------------------
interface slcp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;

	modport source (output valid, output character, input ready);
	modport sink (input valid, input character, output ready);
endinterface

interface slcp_result_if import slcp_pkg::*; ();
	logic        valid;
	logic        ready;
	status_t     status;
	logic        is_extended;
	logic [31:0] identifier;
	logic [3:0]  data_length;
	logic [63:0] data_bytes;

	modport source (output valid, output status, output is_extended, output identifier,
		output data_length, output data_bytes, input ready);
	modport sink (input valid, input status, input is_extended, input identifier,
		input data_length, input data_bytes, output ready);
endinterface

FILE: rtl/slcp_line_parser.sv
// ----------------------------------------------------------------------------
// slcp_line_parser
// Per-line parse state, updated once per character; flags a result on a
// terminator that ends a non-empty line.
// ----------------------------------------------------------------------------
`include "slcan_command_line_parser_macros.svh"

module slcp_line_parser import slcp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] chr,
	output logic       res_valid,
	output result_t    res
);

	kind_t            kind_q, kind_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [31:0]      id_q, id_d;
	logic [3:0]       len_q, len_d;
	logic [63:0]      data_q, data_d;
	logic             bad_q, bad_d;

	logic             is_term;
	logic             is_frame;
	logic [4:0]       nib;
	logic [CNT_W-1:0] digits;
	logic [CNT_W-1:0] two_len;
	logic [CNT_W-1:0] q_pos;
	logic [CNT_W-1:0] expected;

	assign is_term  = (chr == CHAR_CR) || (chr == CHAR_LF);
	assign is_frame = (kind_q == KIND_STD) || (kind_q == KIND_EXT);
	assign nib      = nibble_of(chr);
	assign digits   = (kind_q == KIND_EXT) ? EXT_DIGITS : STD_DIGITS;
	assign two_len  = CNT_W'({len_q, 1'b0});
	assign q_pos    = count_q - digits - CNT_W'(2);
	assign expected = CNT_W'(2) + digits + two_len;

	always_comb begin
		res = '0;
		res.status = ST_ERROR;
		if (is_frame && !bad_q && count_q == expected) begin
			res.status      = ST_FRAME;
			res.is_extended = (kind_q == KIND_EXT);
			res.identifier  = id_q;
			res.data_length = len_q;
			res.data_bytes  = data_q;
		end else if (kind_q == KIND_VER) begin
			res.status = ST_VERSION;
		end
	end

	assign res_valid = step && is_term && (count_q != '0);

	always_comb begin
		kind_d  = kind_q;
		count_d = count_q;
		id_d    = id_q;
		len_d   = len_q;
		data_d  = data_q;
		bad_d   = bad_q;
		if (step) begin
			if (is_term || count_q >= CNT_W'(LINE_CHARS_MAX - 1)) begin
				// end of line or overlong line: drop everything
				kind_d  = KIND_NONE;
				count_d = '0;
				id_d    = '0;
				len_d   = '0;
				data_d  = '0;
				bad_d   = 1'b0;
			end else begin
				count_d = count_q + CNT_W'(1);
				if (count_q == '0) begin
					unique case (chr)
						CHAR_STD: kind_d = KIND_STD;
						CHAR_EXT: kind_d = KIND_EXT;
						CHAR_VER: kind_d = KIND_VER;
						default:  kind_d = KIND_OTHER;
					endcase
				end else if (is_frame && !bad_q) begin
					if (count_q <= digits) begin
						if (nib[4]) begin
							bad_d = 1'b1;
						end else begin
							id_d = {id_q[27:0], nib[3:0]};
						end
					end else if (count_q == digits + CNT_W'(1)) begin
						if (nib > MAX_LEN) begin
							bad_d = 1'b1;
						end else begin
							len_d = nib[3:0];
						end
					end else if (q_pos >= two_len || nib[4]) begin
						bad_d = 1'b1;
					end else begin
						// high nibble first within each byte
						data_d = data_q | (64'(nib[3:0]) << {q_pos[3:1], ~q_pos[0], 2'b00});
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_NONE;
			count_q <= '0;
			id_q    <= '0;
			len_q   <= '0;
			data_q  <= '0;
			bad_q   <= 1'b0;
		end else begin
			kind_q  <= kind_d;
			count_q <= count_d;
			id_q    <= id_d;
			len_q   <= len_d;
			data_q  <= data_d;
			bad_q   <= bad_d;
		end
	end

	`SLCP_ASSERT_NEXT(a_term_clears, step && is_term,
		count_q == '0 && kind_q == KIND_NONE, "line state not cleared after terminator")
	`SLCP_ASSERT_HOLDS(a_kind_set, (count_q == '0) == (kind_q == KIND_NONE),
		"line kind out of step with character count")
	`SLCP_ASSERT_HOLDS(a_err_zero, !(res.status != ST_FRAME && res.data_bytes != '0),
		"non-frame result carries data")

endmodule

FILE: rtl/slcan_command_line_parser.sv
// ----------------------------------------------------------------------------
// slcan_command_line_parser
// SLCAN style command line parser: one host character per word in, one
// parsed command result per terminated non-empty line out.
// ----------------------------------------------------------------------------
// Flow: an accepted terminator waits in the input register and is parsed when
//   that register advances; its result word is then loaded into the output register and shown as valid.
// Throughput: one character per cycle while results are taken; the input
//   register advances only when the output register is free or being drained.
// Reset: arst_n clears the line state and both valid flags at once.
`include "slcan_command_line_parser_macros.svh"

module slcan_command_line_parser import slcp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	slcp_char_if.sink       cmd,
	slcp_result_if.source   result
);

	logic       valid_s1;
	logic [7:0] chr_s1;
	logic       out_valid_q;
	result_t    out_q;
	logic       adv;
	logic       res_valid;
	result_t    res;

	assign adv       = valid_s1 && (!out_valid_q || result.ready);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			chr_s1 <= cmd.character;
		end
	end

	slcp_line_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.chr       (chr_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.status      = out_q.status;
	assign result.is_extended = out_q.is_extended;
	assign result.identifier  = out_q.identifier;
	assign result.data_length = out_q.data_length;
	assign result.data_bytes  = out_q.data_bytes;

	`SLCP_ASSERT_HOLDS(a_no_overwrite, !(adv && res_valid && out_valid_q && !result.ready), "pending result overwritten")
	`SLCP_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(chr_s1), "stalled character lost")
	`SLCP_ASSERT_NEXT(a_out_load, adv && res_valid, out_valid_q, "result not loaded into output register")

endmodule

FILE: test/slcan_command_line_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slcan_command_line_parser_test
// Self-checking bench for the command line parser. Host characters are sent
// with random bursts and gaps. Each accepted character is run through a local
// line parser, and every result word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module slcan_command_line_parser_test import slcp_pkg::*; ();

	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	slcp_char_if   cmd_if();
	slcp_result_if res_if();

	slcan_command_line_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.result (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Line parser state
	kind_t       line_kind = KIND_NONE;
	int unsigned line_len = 0;
	logic [31:0] id_acc = '0;
	logic [3:0]  len_acc = '0;
	logic [63:0] data_acc = '0;
	logic        line_bad = 1'b0;

	result_t     pending_results[$];
	logic [7:0]  line_buf[$];
	int unsigned mismatches = 0;
	int unsigned sent_count = 0;
	int unsigned burst_left = 0;
	logic        steady_send = 1'b0;
	logic        hold_req = 1'b0;
	int unsigned hold_left = 0;
	logic [9:0]  rx_phase = '0;
	int unsigned idle_cycles = 0;

	function automatic int unsigned hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return c - "0";
		end
		if (c >= "a" && c <= "f") begin
			return c - "a" + 10;
		end
		if (c >= "A" && c <= "F") begin
			return c - "A" + 10;
		end
		return 16;
	endfunction

	function automatic void clear_line();
		line_kind = KIND_NONE;
		line_len  = 0;
		id_acc    = '0;
		len_acc   = '0;
		data_acc  = '0;
		line_bad  = 1'b0;
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		result_t     r;
		int unsigned digits;
		int unsigned nib;
		int unsigned q;
		digits = (line_kind == KIND_EXT) ? 8 : 3;
		if (c == CHAR_CR || c == CHAR_LF) begin
			if (line_len == 0) begin
				return;
			end
			r = '0;
			r.status = ST_ERROR;
			if (line_kind == KIND_VER) begin
				r.status = ST_VERSION;
			end else if ((line_kind == KIND_STD || line_kind == KIND_EXT) && !line_bad
					&& line_len == 2 + digits + 2 * len_acc) begin
				r.status      = ST_FRAME;
				r.is_extended = (line_kind == KIND_EXT);
				r.identifier  = id_acc;
				r.data_length = len_acc;
				r.data_bytes  = data_acc;
			end
			pending_results.push_back(r);
			clear_line();
			return;
		end
		// drop the character and the whole line once the store is full
		if (line_len >= LINE_CHARS_MAX - 1) begin
			clear_line();
			return;
		end
		if (line_len == 0) begin
			case (c)
				CHAR_STD: line_kind = KIND_STD;
				CHAR_EXT: line_kind = KIND_EXT;
				CHAR_VER: line_kind = KIND_VER;
				default:  line_kind = KIND_OTHER;
			endcase
		end else if (!line_bad && (line_kind == KIND_STD || line_kind == KIND_EXT)) begin
			nib = hex_value(c);
			if (line_len <= digits) begin
				if (nib > 15) begin
					line_bad = 1'b1;
				end else begin
					id_acc = {id_acc[27:0], nib[3:0]};
				end
			end else if (line_len == digits + 1) begin
				if (nib > 8) begin
					line_bad = 1'b1;
				end else begin
					len_acc = nib[3:0];
				end
			end else begin
				q = line_len - digits - 2;
				if (q >= 2 * len_acc || nib > 15) begin
					line_bad = 1'b1;
				end else begin
					// high nibble first within each byte
					data_acc |= 64'(nib) << (8 * (q / 2) + ((q % 2 == 0) ? 4 : 0));
				end
			end
		end
		line_len++;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10) begin
			return 8'h30 + n;
		end
		return (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + n - 8'd10;
	endfunction

	function automatic logic [7:0] non_term_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CHAR_CR || c == CHAR_LF);
		return c;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do begin
			c = non_term_char();
		end while (hex_value(c) < 16);
		return c;
	endfunction

	function automatic logic [7:0] pick_term();
		return ($urandom_range(0, 1) == 1) ? CHAR_CR : CHAR_LF;
	endfunction

	task automatic send_char(input logic [7:0] c);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				cmd_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_if.valid     <= 1'b1;
		cmd_if.character <= c;
		do begin
			@(posedge clk);
		end while (cmd_if.ready !== 1'b1);
		parse_char(c);
		sent_count++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
	endtask

	task automatic send_line(input logic [7:0] term);
		foreach (line_buf[i]) begin
			send_char(line_buf[i]);
		end
		send_char(term);
	endtask

	task automatic build_frame();
		logic        ext;
		logic [31:0] id;
		int unsigned len;
		logic [7:0]  d;
		ext = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0:       id = '0;
			1:       id = '1;
			default: id = $urandom;
		endcase
		len = $urandom_range(0, 8);
		line_buf = {};
		line_buf.push_back(ext ? CHAR_EXT : CHAR_STD);
		for (int i = (ext ? 7 : 2); i >= 0; i--) begin
			line_buf.push_back(hex_char(id[4 * i +: 4]));
		end
		line_buf.push_back(hex_char(4'(len)));
		for (int b = 0; b < len; b++) begin
			case ($urandom_range(0, 5))
				0:       d = 8'h00;
				1:       d = 8'hff;
				default: d = 8'($urandom);
			endcase
			line_buf.push_back(hex_char(d[7:4]));
			line_buf.push_back(hex_char(d[3:0]));
		end
	endtask

	task automatic test_directed();
		send_text("t0000");
		send_char(CHAR_CR);
		send_text("V");
		send_char(CHAR_LF);
		send_char(CHAR_CR);
		send_text("?");
		send_char(CHAR_CR);
		// mixed-case id, length digit above eight
		send_text("tFfA9");
		send_char(CHAR_CR);
		send_text("tG");
		send_char(CHAR_LF);
		send_char(CHAR_LF);
		send_char(8'hff);
		send_char(8'h00);
		send_char(CHAR_CR);
	endtask

	task automatic test_frames();
		while (sent_count < 900) begin
			build_frame();
			send_line(pick_term());
		end
	endtask

	task automatic test_malformed();
		int unsigned pos;
		int unsigned digits;
		while (sent_count < 1250) begin
			build_frame();
			digits = (line_buf[0] == CHAR_EXT) ? 8 : 3;
			pos = $urandom_range(1, line_buf.size() - 1);
			case ($urandom_range(0, 4))
				0: line_buf.delete(pos);
				1: begin
					line_buf.push_back(hex_char(4'($urandom)));
					if ($urandom_range(0, 1) == 1) begin
						line_buf.push_back(hex_char(4'($urandom)));
					end
				end
				2: line_buf[pos] = non_hex_char();
				3: line_buf[digits + 1] = ($urandom_range(0, 1) == 1)
					? hex_char(4'($urandom_range(9, 15))) : non_hex_char();
				default: line_buf = line_buf[0:pos - 1];
			endcase
			send_line(pick_term());
		end
	endtask

	task automatic test_noise();
		int unsigned n;
		while (sent_count < 1450) begin
			case ($urandom_range(0, 3))
				0:       line_buf = {};
				1:       line_buf = {CHAR_VER};
				2:       line_buf = {($urandom_range(0, 1) == 1) ? CHAR_EXT : CHAR_STD};
				default: line_buf = {8'($urandom)};
			endcase
			n = $urandom_range(0, 10);
			repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
			send_line(pick_term());
		end
	endtask

	task automatic test_overlong();
		int unsigned lens[6] = '{61, 62, 63, 64, 65, 127};
		foreach (lens[k]) begin
			line_buf = {(k % 2 == 0) ? CHAR_VER : non_term_char()};
			while (line_buf.size() < lens[k]) begin
				line_buf.push_back(non_term_char());
			end
			send_line(pick_term());
		end
	endtask

	task automatic test_backpressure();
		steady_send = 1'b1;
		hold_req    = 1'b1;
		repeat (30) begin
			send_char(CHAR_VER);
			send_char(CHAR_CR);
		end
		steady_send = 1'b0;
	endtask

	// Result side: long hold-off on request, otherwise a rotating stall pattern
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			rx_phase <= rx_phase + 10'd1;
			case (rx_phase[9:8])
				2'd0: res_if.ready <= 1'b1;
				2'd1: res_if.ready <= ($urandom_range(0, 1) == 1);
				2'd2: res_if.ready <= ($urandom_range(0, 3) == 0);
				2'd3: res_if.ready <= (rx_phase[2:0] != 3'd0);
			endcase
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result word with none expected, status %0d id %h",
					$time, res_if.status, res_if.identifier);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 64'(want.status), 64'(res_if.status));
				check_field("is_extended", 64'(want.is_extended), 64'(res_if.is_extended));
				check_field("identifier", 64'(want.identifier), 64'(res_if.identifier));
				check_field("data_length", 64'(want.data_length), 64'(res_if.data_length));
				check_field("data_bytes", want.data_bytes, res_if.data_bytes);
			end
		end
	end

	// Stall watchdog: any word moving on either side resets the count
	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)
					|| (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		cmd_if.valid     = 1'b0;
		cmd_if.character = '0;
		res_if.ready     = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_frames();
		test_malformed();
		test_noise();
		test_overlong();
		test_backpressure();
		cmd_if.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
